### rtl/tlsp_pkg.sv
`default_nettype none
package tlsp_pkg;

	typedef enum logic [1:0] {
		LT_GREEN  = 2'd0,
		LT_YELLOW = 2'd1,
		LT_RED    = 2'd2
	} light_t;

	typedef enum logic [1:0] {
		OVR_IDLE  = 2'd0,
		OVR_CLEAR = 2'd1,
		OVR_WALK  = 2'd2
	} ovr_stage_t;

	typedef logic [2:0]  phase_t;
	typedef logic [15:0] ticks_t;

	localparam phase_t PH_NS_GO    = 3'd0;
	localparam phase_t PH_NS_READY = 3'd1;
	localparam phase_t PH_NS_STOP  = 3'd2;
	localparam phase_t PH_EW_GO    = 3'd3;
	localparam phase_t PH_EW_READY = 3'd4;
	localparam phase_t PH_EW_STOP  = 3'd5;

	localparam logic [2:0] REG_GO_TIME    = 3'd0;
	localparam logic [2:0] REG_READY_TIME = 3'd1;
	localparam logic [2:0] REG_STOP_TIME  = 3'd2;
	localparam logic [2:0] REG_CLEAR_TIME = 3'd3;
	localparam logic [2:0] REG_WALK_TIME  = 3'd4;

	localparam ticks_t GO_TIME_RST    = 16'd5000;
	localparam ticks_t READY_TIME_RST = 16'd2000;
	localparam ticks_t STOP_TIME_RST  = 16'd1000;
	localparam ticks_t CLEAR_TIME_RST = 16'd1000;
	localparam ticks_t WALK_TIME_RST  = 16'd2000;

	// Walk bits: bit 0 is NS walk, bit 1 is EW walk.
	localparam logic [1:0] WALK_NS = 2'b01;
	localparam logic [1:0] WALK_EW = 2'b10;

	function automatic light_t pat_ns(input phase_t p);
		light_t l;
		unique case (p)
			PH_NS_GO:                l = LT_GREEN;
			PH_NS_READY, PH_EW_STOP: l = LT_YELLOW;
			default:                 l = LT_RED;
		endcase
		return l;
	endfunction

	function automatic light_t pat_ew(input phase_t p);
		light_t l;
		unique case (p)
			PH_EW_GO:                 l = LT_GREEN;
			PH_NS_STOP, PH_EW_READY:  l = LT_YELLOW;
			default:                  l = LT_RED;
		endcase
		return l;
	endfunction

	function automatic logic [1:0] pat_walk(input phase_t p);
		logic [1:0] w;
		unique case (p)
			PH_NS_GO, PH_NS_READY: w = WALK_NS;
			PH_EW_GO, PH_EW_READY: w = WALK_EW;
			default:               w = 2'b00;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

### rtl/traffic_light_sequencer_ped_override.sv
`default_nettype none
// Channel   Direction  Contents
// s_*       in         one tick transaction: ns_press, ew_press
// m_*       out        lights, walk signals, phase_now, override_busy after the tick
// cfg_*     in         register writes: go, ready, stop, clear, walk time
//
// Each tick transaction is processed combinationally and its result is on m_*
// in the next cycle; one transaction per cycle is sustained while m_tready is
// high, bounded by the single output register. s_tready is low only while a result
// waits and m_tready is low. arst_n resets timers, timing registers and state.
module traffic_light_sequencer_ped_override (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] ns_press, [1] ew_press
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [1:0] ns_light, [3:2] ew_light, [4] ns_walk,
	                                    // [5] ew_walk, [8:6] phase_now, [9] override_busy
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	tlsp_pkg::ticks_t go_time_q, ready_time_q, stop_time_q, clear_time_q, walk_time_q;

	tlsp_pkg::phase_t     phase_q, phase_d;
	tlsp_pkg::ticks_t     phase_timer_q, phase_timer_d;
	tlsp_pkg::ovr_stage_t stage_q, stage_d;
	logic                 dir_q, dir_d;
	tlsp_pkg::ticks_t     ovr_timer_q, ovr_timer_d;
	tlsp_pkg::light_t     light_ns_q, light_ns_d, light_ew_q, light_ew_d;
	logic [1:0]           walk_q, walk_d;

	logic        out_valid_q;
	logic [15:0] out_data_q, out_data_d;

	logic             accept;
	logic             ns_p, ew_p;
	tlsp_pkg::ticks_t ph_len, ovr_len;
	logic             ph_expire, ovr_expire;
	tlsp_pkg::phase_t ph_next;
	logic             do_normal;

	function automatic tlsp_pkg::phase_t phase_t_inc(input tlsp_pkg::phase_t p);
		return p + 3'd1;
	endfunction

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign ns_p     = s_tdata[0];
	assign ew_p     = s_tdata[1];

	// Timers hold ticks already spent; a zero length expires at once.
	always_comb begin
		unique case (phase_q)
			tlsp_pkg::PH_NS_GO, tlsp_pkg::PH_EW_GO:       ph_len = go_time_q;
			tlsp_pkg::PH_NS_READY, tlsp_pkg::PH_EW_READY: ph_len = ready_time_q;
			default:                                      ph_len = stop_time_q;
		endcase
		ovr_len    = (stage_q == tlsp_pkg::OVR_CLEAR) ? clear_time_q : walk_time_q;
		ph_expire  = ({1'b0, phase_timer_q} + 17'd1) >= {1'b0, ph_len};
		ovr_expire = ({1'b0, ovr_timer_q} + 17'd1) >= {1'b0, ovr_len};
		ph_next    = (phase_q >= tlsp_pkg::PH_EW_STOP) ? tlsp_pkg::PH_NS_GO
		                                               : phase_t_inc(phase_q);
	end

	// Next state
	always_comb begin
		phase_d       = phase_q;
		phase_timer_d = phase_timer_q;
		stage_d       = stage_q;
		dir_d         = dir_q;
		ovr_timer_d   = ovr_timer_q;
		light_ns_d    = light_ns_q;
		light_ew_d    = light_ew_q;
		walk_d        = walk_q;
		do_normal     = 1'b0;

		unique case (stage_q)
			tlsp_pkg::OVR_IDLE: begin
				if (ns_p || ew_p) begin
					dir_d       = !ns_p;
					stage_d     = tlsp_pkg::OVR_CLEAR;
					ovr_timer_d = '0;
					if (ns_p) begin
						light_ew_d = tlsp_pkg::LT_YELLOW;
						walk_d     = walk_q & tlsp_pkg::WALK_NS;
					end else begin
						light_ns_d = tlsp_pkg::LT_YELLOW;
						walk_d     = walk_q & tlsp_pkg::WALK_EW;
					end
				end else begin
					do_normal = 1'b1;
				end
			end
			tlsp_pkg::OVR_CLEAR: begin
				if (ovr_expire) begin
					stage_d     = tlsp_pkg::OVR_WALK;
					ovr_timer_d = '0;
					if (!dir_q) begin
						light_ns_d = tlsp_pkg::LT_GREEN;
						light_ew_d = tlsp_pkg::LT_RED;
						walk_d     = tlsp_pkg::WALK_NS;
					end else begin
						light_ns_d = tlsp_pkg::LT_RED;
						light_ew_d = tlsp_pkg::LT_GREEN;
						walk_d     = tlsp_pkg::WALK_EW;
					end
				end else begin
					ovr_timer_d = ovr_timer_q + 16'd1;
				end
			end
			tlsp_pkg::OVR_WALK: begin
				if (ovr_expire) begin
					stage_d     = tlsp_pkg::OVR_IDLE;
					ovr_timer_d = '0;
					do_normal   = 1'b1;
				end else begin
					ovr_timer_d = ovr_timer_q + 16'd1;
				end
			end
			default: begin
				stage_d = tlsp_pkg::OVR_IDLE;
			end
		endcase

		if (do_normal) begin
			if (ph_expire) begin
				phase_d       = ph_next;
				phase_timer_d = '0;
				light_ns_d    = tlsp_pkg::pat_ns(ph_next);
				light_ew_d    = tlsp_pkg::pat_ew(ph_next);
				walk_d        = tlsp_pkg::pat_walk(ph_next);
			end else begin
				phase_timer_d = phase_timer_q + 16'd1;
			end
		end
	end

	// Result word, taken from the state after this tick
	always_comb begin
		out_data_d       = '0;
		out_data_d[1:0]  = light_ns_d;
		out_data_d[3:2]  = light_ew_d;
		out_data_d[4]    = walk_d[0];
		out_data_d[5]    = walk_d[1];
		out_data_d[8:6]  = phase_d;
		out_data_d[9]    = (stage_d != tlsp_pkg::OVR_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_time_q    <= tlsp_pkg::GO_TIME_RST;
			ready_time_q <= tlsp_pkg::READY_TIME_RST;
			stop_time_q  <= tlsp_pkg::STOP_TIME_RST;
			clear_time_q <= tlsp_pkg::CLEAR_TIME_RST;
			walk_time_q  <= tlsp_pkg::WALK_TIME_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tlsp_pkg::REG_GO_TIME:    go_time_q    <= cfg_data;
				tlsp_pkg::REG_READY_TIME: ready_time_q <= cfg_data;
				tlsp_pkg::REG_STOP_TIME:  stop_time_q  <= cfg_data;
				tlsp_pkg::REG_CLEAR_TIME: clear_time_q <= cfg_data;
				tlsp_pkg::REG_WALK_TIME:  walk_time_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= tlsp_pkg::PH_NS_GO;
			phase_timer_q <= '0;
			stage_q       <= tlsp_pkg::OVR_IDLE;
			dir_q         <= 1'b0;
			ovr_timer_q   <= '0;
			light_ns_q    <= tlsp_pkg::LT_GREEN;
			light_ew_q    <= tlsp_pkg::LT_RED;
			walk_q        <= tlsp_pkg::WALK_NS;
		end else if (accept) begin
			phase_q       <= phase_d;
			phase_timer_q <= phase_timer_d;
			stage_q       <= stage_d;
			dir_q         <= dir_d;
			ovr_timer_q   <= ovr_timer_d;
			light_ns_q    <= light_ns_d;
			light_ew_q    <= light_ew_d;
			walk_q        <= walk_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= out_data_d;
		end
	end

endmodule
`default_nettype wire

### test/traffic_light_sequencer_ped_override_tb.sv
`default_nettype none
module traffic_light_sequencer_ped_override_tb;
	import tlsp_pkg::*;

	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		light_t ns_light;
		light_t ew_light;
		logic   ns_walk;
		logic   ew_walk;
		phase_t phase_now;
		logic   busy;
	} lamp_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;     // [0] ns_press, [1] ew_press
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [15:0] m_tdata;            // [1:0] ns_light, [3:2] ew_light, [4] ns_walk,
	                                 // [5] ew_walk, [8:6] phase_now, [9] override_busy
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_data = 16'd0;

	traffic_light_sequencer_ped_override u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Intersection model state and its own copy of the timing registers.
	ticks_t     go_len, ready_len, stop_len, clear_len, walk_len;
	phase_t     cur_phase;
	ticks_t     phase_ticks;
	ovr_stage_t stage;
	logic       ovr_ew;
	ticks_t     ovr_ticks;
	light_t     lamp_ns, lamp_ew;
	logic [1:0] walk;

	lamp_state_t expected_lamps[$];
	int errors = 0;
	int ticks_sent = 0;
	int results_seen = 0;
	int overrides_started = 0;
	int settings_applied = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int stall_left = 0;

	function automatic ticks_t phase_len(input phase_t p);
		case (p)
			PH_NS_GO, PH_EW_GO:       return go_len;
			PH_NS_READY, PH_EW_READY: return ready_len;
			default:                  return stop_len;
		endcase
	endfunction

	function automatic void show_phase_pattern();
		case (cur_phase)
			PH_NS_GO:    begin lamp_ns = LT_GREEN;  lamp_ew = LT_RED;    walk = WALK_NS; end
			PH_NS_READY: begin lamp_ns = LT_YELLOW; lamp_ew = LT_RED;    walk = WALK_NS; end
			PH_NS_STOP:  begin lamp_ns = LT_RED;    lamp_ew = LT_YELLOW; walk = 2'b00;   end
			PH_EW_GO:    begin lamp_ns = LT_RED;    lamp_ew = LT_GREEN;  walk = WALK_EW; end
			PH_EW_READY: begin lamp_ns = LT_RED;    lamp_ew = LT_YELLOW; walk = WALK_EW; end
			default:     begin lamp_ns = LT_YELLOW; lamp_ew = LT_RED;    walk = 2'b00;   end
		endcase
	endfunction

	function automatic void reset_intersection();
		go_len = GO_TIME_RST;
		ready_len = READY_TIME_RST;
		stop_len = STOP_TIME_RST;
		clear_len = CLEAR_TIME_RST;
		walk_len = WALK_TIME_RST;
		cur_phase = PH_NS_GO;
		phase_ticks = '0;
		stage = OVR_IDLE;
		ovr_ew = 1'b0;
		ovr_ticks = '0;
		show_phase_pattern();
	endfunction

	// A length of zero compares like a length of one, since the next count
	// is always at least one.
	function automatic void phase_tick();
		logic [16:0] nxt;
		nxt = {1'b0, phase_ticks} + 17'd1;
		if (nxt >= {1'b0, phase_len(cur_phase)}) begin
			cur_phase = (cur_phase == PH_EW_STOP) ? PH_NS_GO : cur_phase + 3'd1;
			phase_ticks = '0;
			show_phase_pattern();
		end else begin
			phase_ticks = nxt[15:0];
		end
	endfunction

	function automatic lamp_state_t advance_intersection(input logic ns_p, input logic ew_p);
		logic [16:0] nxt;
		lamp_state_t r;
		nxt = {1'b0, ovr_ticks} + 17'd1;
		if (stage == OVR_IDLE) begin
			if (ns_p || ew_p) begin
				ovr_ew = !ns_p;
				stage = OVR_CLEAR;
				ovr_ticks = '0;
				overrides_started++;
				if (!ovr_ew) begin
					lamp_ew = LT_YELLOW;
					walk &= WALK_NS;
				end else begin
					lamp_ns = LT_YELLOW;
					walk &= WALK_EW;
				end
			end else begin
				phase_tick();
			end
		end else if (stage == OVR_CLEAR) begin
			if (nxt >= {1'b0, clear_len}) begin
				stage = OVR_WALK;
				ovr_ticks = '0;
				lamp_ns = ovr_ew ? LT_RED : LT_GREEN;
				lamp_ew = ovr_ew ? LT_GREEN : LT_RED;
				walk = ovr_ew ? WALK_EW : WALK_NS;
			end else begin
				ovr_ticks = nxt[15:0];
			end
		end else if (nxt >= {1'b0, walk_len}) begin
			// The tick that ends the walk also counts toward the paused phase.
			stage = OVR_IDLE;
			ovr_ticks = '0;
			phase_tick();
		end else begin
			ovr_ticks = nxt[15:0];
		end
		r.ns_light = lamp_ns;
		r.ew_light = lamp_ew;
		r.ns_walk = walk[0];
		r.ew_walk = walk[1];
		r.phase_now = cur_phase;
		r.busy = (stage != OVR_IDLE);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at result %0d: %s", results_seen, msg);
		errors++;
	endtask

	// Results are checked before the tick accepted at the same edge is
	// predicted; a result is registered, so it always trails its tick.
	always @(posedge clk or negedge arst_n) begin : scoreboard
		lamp_state_t want;
		if (!arst_n) begin
			reset_intersection();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_lamps.size() == 0) begin
					report_mismatch("result transaction with no tick outstanding");
				end else begin
					want = expected_lamps.pop_front();
					if (m_tdata[1:0] !== want.ns_light)
						report_mismatch($sformatf("ns_light got %0d want %0d",
							m_tdata[1:0], want.ns_light));
					if (m_tdata[3:2] !== want.ew_light)
						report_mismatch($sformatf("ew_light got %0d want %0d",
							m_tdata[3:2], want.ew_light));
					if (m_tdata[4] !== want.ns_walk)
						report_mismatch($sformatf("ns_walk got %0d want %0d",
							m_tdata[4], want.ns_walk));
					if (m_tdata[5] !== want.ew_walk)
						report_mismatch($sformatf("ew_walk got %0d want %0d",
							m_tdata[5], want.ew_walk));
					if (m_tdata[8:6] !== want.phase_now)
						report_mismatch($sformatf("phase_now got %0d want %0d",
							m_tdata[8:6], want.phase_now));
					if (m_tdata[9] !== want.busy)
						report_mismatch($sformatf("override_busy got %0d want %0d",
							m_tdata[9], want.busy));
				end
				results_seen++;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_GO_TIME:    go_len = cfg_data;
					REG_READY_TIME: ready_len = cfg_data;
					REG_STOP_TIME:  stop_len = cfg_data;
					REG_CLEAR_TIME: clear_len = cfg_data;
					REG_WALK_TIME:  walk_len = cfg_data;
					default:        ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_lamps.push_back(advance_intersection(s_tdata[0], s_tdata[1]));
		end
	end

	// Receiver back-pressure in random bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 6) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timed out after %0d cycles with no transaction.", QUIET_LIMIT);
		$display("FAIL traffic_light_sequencer_ped_override");
		$finish;
	end

	task automatic send_tick(input logic ns, input logic ew);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, ew, ns};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 5);
			s_tvalid <= 1'b0;
			repeat (gap) begin
				s_tdata <= 8'($urandom);
				@(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_lamps.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input ticks_t value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_timing(input ticks_t go, input ticks_t ready, input ticks_t stop,
			input ticks_t clear, input ticks_t walk_t);
		set_reg(REG_GO_TIME, go);
		set_reg(REG_READY_TIME, ready);
		set_reg(REG_STOP_TIME, stop);
		set_reg(REG_CLEAR_TIME, clear);
		set_reg(REG_WALK_TIME, walk_t);
		cfg_wr_en <= 1'b0;
		settings_applied++;
	endtask

	task automatic apply_random_timing(input int max_len);
		apply_timing(ticks_t'($urandom_range(1, max_len)), ticks_t'($urandom_range(1, max_len)),
			ticks_t'($urandom_range(1, max_len)), ticks_t'($urandom_range(1, max_len)),
			ticks_t'($urandom_range(1, max_len)));
	endtask

	// kind bit 0 is an NS press and bit 1 an EW press.
	task automatic run_random(input int n, input int press_pct);
		int kind;
		repeat (n) begin
			kind = ($urandom_range(0, 99) < press_pct) ? $urandom_range(1, 3) : 0;
			send_tick(kind[0], kind[1]);
		end
	endtask

	// Reset timing, then a press with both buttons and a press that lands
	// inside the running override.
	task automatic test_reset_defaults();
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		drain_results();
	endtask

	// Short phases walk the whole cycle; presses then hit the end of the
	// clearance and the tick that ends the walk.
	task automatic test_phase_walk();
		apply_timing(16'd2, 16'd1, 16'd1, 16'd1, 16'd1);
		repeat (10) send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		drain_results();
	endtask

	task automatic test_zero_length();
		apply_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		drain_results();
	endtask

	task automatic test_random_short();
		apply_random_timing(6);
		run_random(150, 15);
		// Hold the sender until every result has come back.
		drain_results();
		apply_random_timing(6);
		run_random(150, 25);
		drain_results();
	endtask

	task automatic test_extreme_lengths();
		apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
		run_random(80, 30);
		drain_results();
		apply_timing(16'd1, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
		run_random(60, 20);
		drain_results();
	endtask

	task automatic test_back_to_back();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		apply_random_timing(20);
		run_random(270, 10);
		drain_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_phase_walk();
		test_zero_length();
		test_random_short();
		test_extreme_lengths();
		test_back_to_back();
		repeat (8) @(posedge clk);
		if (expected_lamps.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_lamps.size()));
		$display("Sent %0d ticks, checked %0d results under %0d timing settings.",
			ticks_sent, results_seen, settings_applied);
		$display("Pedestrian overrides started: %0d; mismatches: %0d.",
			overrides_started, errors);
		if (errors == 0)
			$display("PASS traffic_light_sequencer_ped_override");
		else
			$display("FAIL traffic_light_sequencer_ped_override");
		$finish;
	end

endmodule
`default_nettype wire
